FILE: rtl/vfcm_pkg.sv
// Package: shared types and constants for the voxel face culling mesher.
package vfcm_pkg;

	localparam int LEVELS     = 10;
	localparam int MAX_VOXELS = 4096;
	localparam int IDX_W      = 12;
	localparam int CNT_W      = 13;
	localparam int KEY_W      = 30;
	localparam int CRD_W      = 11;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_GEN    = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_KEY,
		ST_DECODE,
		ST_SETUP,
		ST_PROBE,
		ST_WAIT,
		ST_STEP,
		ST_FINAL,
		ST_FCHECK,
		ST_VERT,
		ST_TRI
	} state_t;

	// offsets for face f, triangle t, corner c at index 6f+3t+c
	function automatic logic [2:0] face_tri(input logic [2:0] f, input logic t,
			input logic [1:0] c);
		logic [2:0] r;
		r = 3'd0;
		case ({f, t})
			4'd0: case (c) 2'd0: r = 3'd0; 2'd1: r = 3'd4; default: r = 3'd1; endcase
			4'd1: case (c) 2'd0: r = 3'd1; 2'd1: r = 3'd4; default: r = 3'd5; endcase
			4'd2: case (c) 2'd0: r = 3'd1; 2'd1: r = 3'd5; default: r = 3'd2; endcase
			4'd3: case (c) 2'd0: r = 3'd2; 2'd1: r = 3'd5; default: r = 3'd6; endcase
			4'd4: case (c) 2'd0: r = 3'd2; 2'd1: r = 3'd6; default: r = 3'd3; endcase
			4'd5: case (c) 2'd0: r = 3'd3; 2'd1: r = 3'd6; default: r = 3'd7; endcase
			4'd6: case (c) 2'd0: r = 3'd3; 2'd1: r = 3'd7; default: r = 3'd0; endcase
			4'd7: case (c) 2'd0: r = 3'd0; 2'd1: r = 3'd7; default: r = 3'd4; endcase
			4'd8: case (c) 2'd0: r = 3'd0; 2'd1: r = 3'd2; default: r = 3'd3; endcase
			4'd9: case (c) 2'd0: r = 3'd0; 2'd1: r = 3'd1; default: r = 3'd2; endcase
			4'd10: case (c) 2'd0: r = 3'd6; 2'd1: r = 3'd4; default: r = 3'd7; endcase
			4'd11: case (c) 2'd0: r = 3'd5; 2'd1: r = 3'd4; default: r = 3'd6; endcase
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] morton_enc(input logic [LEVELS-1:0] x,
			input logic [LEVELS-1:0] y, input logic [LEVELS-1:0] z);
		logic [KEY_W-1:0] k;
		k = '0;
		for (int i = 0; i < LEVELS; i++) begin
			k[3*i]   = x[i];
			k[3*i+1] = y[i];
			k[3*i+2] = z[i];
		end
		return k;
	endfunction

endpackage

FILE: rtl/vfcm_search.sv
// Binary search unit: one compare and halving step per table read.
module vfcm_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vfcm_pkg::CNT_W-1:0]  lo_in,
	input  logic [vfcm_pkg::CNT_W-1:0]  hi_in,
	input  logic [vfcm_pkg::KEY_W-1:0]  key_in,
	input  logic                        step,
	input  logic [vfcm_pkg::KEY_W-1:0]  rd_data,
	output logic [vfcm_pkg::IDX_W-1:0]  rd_addr,
	output logic                        active,
	output logic                        found
);
	logic [vfcm_pkg::CNT_W-1:0] lo_q, hi_q, end_q, mid;
	logic [vfcm_pkg::KEY_W-1:0] key_q;

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign active  = lo_q < hi_q;
	assign rd_addr = active ? mid[vfcm_pkg::IDX_W-1:0] : lo_q[vfcm_pkg::IDX_W-1:0];
	assign found   = (lo_q < end_q) && (rd_data == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q  <= '0;
			hi_q  <= '0;
			end_q <= '0;
		end else if (start) begin
			lo_q  <= lo_in;
			hi_q  <= hi_in;
			end_q <= hi_in;
		end else if (step) begin
			if (rd_data < key_q) lo_q <= mid + 1'b1;
			else hi_q <= mid;
		end
	end

	always_ff @(posedge clk) begin
		if (start) key_q <= key_in;
	end
endmodule

FILE: rtl/voxel_face_cull_mesher.sv
// Voxel mesher with hidden-face culling over a sorted Morton key table.
// Generate reads the key, then runs six binary searches through one shared
// compare unit and one table read port (at most about 13 probes for a
// 4096-entry range), then emits 8 vertex transfers, then 2 triangle
// transfers per visible face, one per cycle when not stalled, with a face
// check before each face. The input stays stalled for the whole
// generate run.
module voxel_face_cull_mesher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [29:0] voxel_key,
	input  logic [11:0] entry_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [10:0] vert_x,
	output logic [10:0] vert_y,
	output logic [10:0] vert_z,
	output logic [31:0] tri_a,
	output logic [31:0] tri_b,
	output logic [31:0] tri_c,
	output logic [5:0]  face_mask,
	output logic        last
);
	localparam int L = vfcm_pkg::LEVELS;

	vfcm_pkg::state_t state_q, state_d;
	logic [vfcm_pkg::KEY_W-1:0] mem [vfcm_pkg::MAX_VOXELS];
	logic [vfcm_pkg::KEY_W-1:0] rd_q;
	logic [vfcm_pkg::IDX_W-1:0] rd_addr, s_addr, idx_q;
	logic [vfcm_pkg::CNT_W-1:0] cnt_q;
	logic [31:0] vc_q;
	logic [L-1:0] x_q, y_q, z_q, nx, ny, nz;
	logic [2:0] side_q, cnt8_q;
	logic [5:0] mask_q;
	logic       ok;
	logic [vfcm_pkg::CNT_W-1:0] s_lo, s_hi;
	logic s_start, s_step, s_act, s_found;
	logic accept, take, wr_en;

	assign accept = in_valid && !in_stall;
	assign take   = out_valid && !out_stall;
	assign in_stall = state_q != vfcm_pkg::ST_IDLE;
	assign wr_en  = accept && func == vfcm_pkg::FUNC_APPEND && cnt_q < vfcm_pkg::MAX_VOXELS;

	always_ff @(posedge clk) begin
		if (wr_en) mem[cnt_q[vfcm_pkg::IDX_W-1:0]] <= voxel_key;
		rd_q <= mem[rd_addr];
	end

	// side order: y+1, z+1, x+1, x-1, z-1, y-1
	always_comb begin
		nx = x_q; ny = y_q; nz = z_q; ok = 1'b1;
		s_lo = {1'b0, idx_q}; s_hi = cnt_q;
		case (side_q)
			3'd0: begin ny = y_q + 1'b1; ok = ~&y_q; end
			3'd1: begin nz = z_q + 1'b1; ok = ~&z_q; end
			3'd2: begin nx = x_q + 1'b1; ok = ~&x_q; end
			3'd3: begin nx = x_q - 1'b1; ok = |x_q; s_lo = '0; s_hi = {1'b0, idx_q}; end
			3'd4: begin nz = z_q - 1'b1; ok = |z_q; s_lo = '0; s_hi = {1'b0, idx_q}; end
			default: begin ny = y_q - 1'b1; ok = |y_q; s_lo = '0; s_hi = {1'b0, idx_q}; end
		endcase
	end

	vfcm_search u_search (
		.clk, .arst_n,
		.start(s_start), .lo_in(s_lo), .hi_in(s_hi),
		.key_in(vfcm_pkg::morton_enc(nx, ny, nz)),
		.step(s_step), .rd_data(rd_q), .rd_addr(s_addr),
		.active(s_act), .found(s_found)
	);

	assign rd_addr = (state_q == vfcm_pkg::ST_IDLE) ? entry_index :
		(state_q == vfcm_pkg::ST_RD_KEY) ? idx_q : s_addr;

	logic [2:0] fidx;
	logic [2:0] dv;
	always_comb begin
		fidx = side_q;
		dv = cnt8_q;
	end

	always_comb begin
		state_d = state_q;
		s_start = 1'b0;
		s_step  = 1'b0;
		case (state_q)
			vfcm_pkg::ST_IDLE:
				if (accept && func == vfcm_pkg::FUNC_GEN && {1'b0, entry_index} < cnt_q)
					state_d = vfcm_pkg::ST_RD_KEY;
			vfcm_pkg::ST_RD_KEY: state_d = vfcm_pkg::ST_DECODE;
			vfcm_pkg::ST_DECODE: state_d = vfcm_pkg::ST_SETUP;
			vfcm_pkg::ST_SETUP: begin
				s_start = 1'b1;
				state_d = ok ? vfcm_pkg::ST_PROBE : vfcm_pkg::ST_STEP;
			end
			vfcm_pkg::ST_PROBE: state_d = vfcm_pkg::ST_WAIT;
			vfcm_pkg::ST_WAIT: begin
				if (s_act) begin
					s_step = 1'b1;
					state_d = vfcm_pkg::ST_PROBE;
				end else state_d = vfcm_pkg::ST_FINAL;
			end
			vfcm_pkg::ST_FINAL: state_d = vfcm_pkg::ST_STEP;
			vfcm_pkg::ST_STEP:
				state_d = (side_q == 3'd5) ? vfcm_pkg::ST_VERT : vfcm_pkg::ST_SETUP;
			vfcm_pkg::ST_VERT:
				if (take && cnt8_q == 3'd7) state_d = vfcm_pkg::ST_FCHECK;
			vfcm_pkg::ST_FCHECK:
				if (side_q == 3'd6) state_d = vfcm_pkg::ST_IDLE;
				else if (mask_q[side_q]) state_d = vfcm_pkg::ST_TRI;
			vfcm_pkg::ST_TRI:
				if (take && cnt8_q[0]) state_d = vfcm_pkg::ST_FCHECK;
			default: state_d = vfcm_pkg::ST_IDLE;
		endcase
	end

	// index of the last visible face, for the final flag
	logic [2:0] last_face;
	always_comb begin
		last_face = 3'd7;
		for (int i = 0; i < 6; i++) if (mask_q[i]) last_face = 3'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfcm_pkg::ST_IDLE;
			cnt_q   <= '0;
			vc_q    <= '0;
			side_q  <= '0;
			cnt8_q  <= '0;
			mask_q  <= '0;
			idx_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept && func == vfcm_pkg::FUNC_CLEAR) begin
				cnt_q <= '0;
				vc_q  <= '0;
			end
			if (wr_en) cnt_q <= cnt_q + 1'b1;
			case (state_q)
				vfcm_pkg::ST_IDLE: begin
					if (accept) idx_q <= entry_index;
					side_q <= '0;
					mask_q <= 6'h3F;
				end
				vfcm_pkg::ST_DECODE:
					for (int i = 0; i < L; i++) begin
						x_q[i] <= rd_q[3*i];
						y_q[i] <= rd_q[3*i+1];
						z_q[i] <= rd_q[3*i+2];
					end
				vfcm_pkg::ST_FINAL:
					if (s_found)
						case (side_q)
							3'd0: mask_q[5] <= 1'b0;
							3'd1: mask_q[2] <= 1'b0;
							3'd2: mask_q[1] <= 1'b0;
							3'd3: mask_q[3] <= 1'b0;
							3'd4: mask_q[0] <= 1'b0;
							default: mask_q[4] <= 1'b0;
						endcase
				vfcm_pkg::ST_STEP: begin
					side_q <= (side_q == 3'd5) ? 3'd0 : side_q + 1'b1;
					cnt8_q <= '0;
				end
				vfcm_pkg::ST_VERT:
					if (take) cnt8_q <= cnt8_q + 1'b1;
				vfcm_pkg::ST_FCHECK: begin
					cnt8_q <= '0;
					if (side_q == 3'd6) vc_q <= vc_q + 32'd8;
					else if (!mask_q[side_q]) side_q <= side_q + 1'b1;
				end
				vfcm_pkg::ST_TRI:
					if (take) begin
						cnt8_q <= cnt8_q + 1'b1;
						if (cnt8_q[0]) side_q <= side_q + 1'b1;
					end
				default: ;
			endcase
		end
	end

	assign out_valid = state_q == vfcm_pkg::ST_VERT || state_q == vfcm_pkg::ST_TRI;
	assign kind      = state_q == vfcm_pkg::ST_TRI;
	assign face_mask = mask_q;
	assign vert_x = kind ? '0 : 11'({1'b0, x_q} + 11'(dv == 3'd1 || dv == 3'd2 ||
		dv == 3'd5 || dv == 3'd6));
	assign vert_y = kind ? '0 : 11'({1'b0, y_q} + 11'(dv[2]));
	assign vert_z = kind ? '0 : 11'({1'b0, z_q} + 11'(dv[1]));
	assign tri_a = kind ? vc_q + 32'(vfcm_pkg::face_tri(fidx, cnt8_q[0], 2'd0)) : '0;
	assign tri_b = kind ? vc_q + 32'(vfcm_pkg::face_tri(fidx, cnt8_q[0], 2'd1)) : '0;
	assign tri_c = kind ? vc_q + 32'(vfcm_pkg::face_tri(fidx, cnt8_q[0], 2'd2)) : '0;
	assign last = kind ? (cnt8_q[0] && side_q == last_face)
		: (cnt8_q == 3'd7 && mask_q == '0);
endmodule

FILE: rtl/vfcm_checker.sv
// Port-level checker for the voxel face culling mesher.
module vfcm_props (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       kind,
	input logic [5:0] face_mask,
	input logic       last
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during output run");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last))
		else $error("stalled output changed");
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> $stable(face_mask))
		else $error("face mask changed within run");
	a_tri: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> face_mask != 6'd0) else $error("triangle without face");
endmodule

bind voxel_face_cull_mesher vfcm_props u_chk (.*);

FILE: verif/vfcm_checker.sv
// Checker: predicts mesher results from accepted inputs and compares every output transfer.
module vfcm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  func,
	input  logic [29:0] voxel_key,
	input  logic [11:0] entry_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        kind,
	input  logic [10:0] vert_x,
	input  logic [10:0] vert_y,
	input  logic [10:0] vert_z,
	input  logic [31:0] tri_a,
	input  logic [31:0] tri_b,
	input  logic [31:0] tri_c,
	input  logic [5:0]  face_mask,
	input  logic        last,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        kind;
		logic [10:0] x;
		logic [10:0] y;
		logic [10:0] z;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [5:0]  mask;
		logic        last;
	} mesh_out_t;

	mesh_out_t  mesh_q[$];
	logic [vfcm_pkg::KEY_W-1:0] keys[vfcm_pkg::MAX_VOXELS];
	int unsigned key_cnt;
	logic [31:0] vcount;

	const int tri_ofs[6][6] = '{
		'{0, 4, 1, 1, 4, 5},
		'{1, 5, 2, 2, 5, 6},
		'{2, 6, 3, 3, 6, 7},
		'{3, 7, 0, 0, 7, 4},
		'{0, 2, 3, 0, 1, 2},
		'{6, 4, 7, 5, 4, 6}
	};

	assign pending = mesh_q.size();

	function automatic logic [31:0] encode_key(int x, int y, int z);
		logic [31:0] k;
		k = 0;
		for (int i = 0; i < vfcm_pkg::LEVELS; i++) begin
			k[3*i]   = x[i];
			k[3*i+1] = y[i];
			k[3*i+2] = z[i];
		end
		return k;
	endfunction

	function automatic bit has_neighbor(int x, int y, int z, int unsigned lo,
			int unsigned hi);
		int unsigned top, mid;
		logic [31:0] k;
		int lim;
		lim = (1 << vfcm_pkg::LEVELS) - 1;
		if (x < 0 || y < 0 || z < 0 || x > lim || y > lim || z > lim)
			return 0;
		k = encode_key(x, y, z);
		top = hi;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if ({2'b0, keys[mid]} < k)
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo < top && {2'b0, keys[lo]} == k;
	endfunction

	task automatic predict_mesh(logic [1:0] f, logic [29:0] key, logic [11:0] idx);
		int x, y, z;
		logic [5:0] sides;
		mesh_out_t r;
		if (f == vfcm_pkg::FUNC_CLEAR) begin
			key_cnt = 0;
			vcount = 0;
			return;
		end
		if (f == vfcm_pkg::FUNC_APPEND) begin
			if (key_cnt < vfcm_pkg::MAX_VOXELS) begin
				keys[key_cnt] = key;
				key_cnt++;
			end
			return;
		end
		if (f != vfcm_pkg::FUNC_GEN || idx >= key_cnt)
			return;
		x = 0; y = 0; z = 0;
		for (int i = 0; i < vfcm_pkg::LEVELS; i++) begin
			x[i] = keys[idx][3*i];
			y[i] = keys[idx][3*i+1];
			z[i] = keys[idx][3*i+2];
		end
		sides = 6'h3f;
		if (has_neighbor(x, y + 1, z, idx, key_cnt)) sides[5] = 0;
		if (has_neighbor(x, y, z + 1, idx, key_cnt)) sides[2] = 0;
		if (has_neighbor(x + 1, y, z, idx, key_cnt)) sides[1] = 0;
		if (has_neighbor(x - 1, y, z, 0, idx)) sides[3] = 0;
		if (has_neighbor(x, y, z - 1, 0, idx)) sides[0] = 0;
		if (has_neighbor(x, y - 1, z, 0, idx)) sides[4] = 0;
		for (int v = 0; v < 8; v++) begin
			r = '0;
			r.x = 11'(x + ((v == 1 || v == 2 || v == 5 || v == 6) ? 1 : 0));
			r.y = 11'(y + (v >= 4 ? 1 : 0));
			r.z = 11'(z + (((v & 3) >= 2) ? 1 : 0));
			r.mask = sides;
			mesh_q = {mesh_q, r};
		end
		for (int fc = 0; fc < 6; fc++) begin
			if (!sides[fc])
				continue;
			for (int t = 0; t < 2; t++) begin
				r = '0;
				r.kind = 1;
				r.a = vcount + tri_ofs[fc][3*t];
				r.b = vcount + tri_ofs[fc][3*t+1];
				r.c = vcount + tri_ofs[fc][3*t+2];
				r.mask = sides;
				mesh_q = {mesh_q, r};
			end
		end
		mesh_q[mesh_q.size()-1].last = 1;
		vcount = vcount + 8;
	endtask

	always @(posedge clk or negedge arst_n) begin
		mesh_out_t e;
		if (!arst_n) begin
			key_cnt = 0;
			vcount = 0;
			fail_count = 0;
			mesh_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (mesh_q.size() == 0) begin
					$error("unexpected output transfer");
					fail_count++;
				end else begin
					e = mesh_q.pop_front();
					if (kind !== e.kind) begin
						$error("kind exp %0d got %0d", e.kind, kind); fail_count++;
					end
					if (vert_x !== e.x) begin
						$error("vert_x exp %0d got %0d", e.x, vert_x); fail_count++;
					end
					if (vert_y !== e.y) begin
						$error("vert_y exp %0d got %0d", e.y, vert_y); fail_count++;
					end
					if (vert_z !== e.z) begin
						$error("vert_z exp %0d got %0d", e.z, vert_z); fail_count++;
					end
					if (tri_a !== e.a) begin
						$error("tri_a exp %0d got %0d", e.a, tri_a); fail_count++;
					end
					if (tri_b !== e.b) begin
						$error("tri_b exp %0d got %0d", e.b, tri_b); fail_count++;
					end
					if (tri_c !== e.c) begin
						$error("tri_c exp %0d got %0d", e.c, tri_c); fail_count++;
					end
					if (face_mask !== e.mask) begin
						$error("face_mask exp %0h got %0h", e.mask, face_mask);
						fail_count++;
					end
					if (last !== e.last) begin
						$error("last exp %0d got %0d", e.last, last); fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_mesh(func, voxel_key, entry_index);
		end
	end

endmodule

FILE: verif/tb.sv
// Testbench top: drives all four function codes into the mesher and reports the verdict.
module tb;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [29:0] voxel_key;
	logic [11:0] entry_index;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [10:0] vert_x, vert_y, vert_z;
	logic [31:0] tri_a, tri_b, tri_c;
	logic [5:0]  face_mask;
	logic        last;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	int          cur_count;
	int          sent;
	bit          hold_long;
	bit          stim_done;

	voxel_face_cull_mesher uut (.*);
	vfcm_checker chk (.*);

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		func = vfcm_pkg::FUNC_CLEAR;
		voxel_key = '0;
		entry_index = '0;
		hold_long = 1'b0;
		stim_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int short_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	// receiver: random stalls, one long hold while the sender keeps offering
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_long = 1'b0;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				g = short_gap();
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send(logic [1:0] f, logic [29:0] k, logic [11:0] idx, bit gaps);
		int g;
		if (gaps && $urandom_range(0, 2) == 0) begin
			g = short_gap();
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		func <= f;
		voxel_key <= k;
		entry_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (f == vfcm_pkg::FUNC_CLEAR) cur_count = 0;
		if (f == vfcm_pkg::FUNC_APPEND && cur_count < vfcm_pkg::MAX_VOXELS) cur_count++;
	endtask

	// clear, then append a sorted cluster of voxels in a small cube, with random holes
	task automatic build_cluster(int bx, int by, int bz, int sz, bit gaps);
		logic [vfcm_pkg::KEY_W-1:0] ks[$];
		for (int x = 0; x < sz; x++)
			for (int y = 0; y < sz; y++)
				for (int z = 0; z < sz; z++)
					if ($urandom_range(0, 3) != 0)
						ks = {ks, vfcm_pkg::morton_enc(10'(bx + x), 10'(by + y),
							10'(bz + z))};
		ks.sort();
		send(vfcm_pkg::FUNC_CLEAR, 30'($urandom), 12'($urandom), gaps);
		foreach (ks[i]) send(vfcm_pkg::FUNC_APPEND, ks[i], 12'($urandom), gaps);
	endtask

	initial begin
		int sz, lim;
		logic [29:0] rk;
		cur_count = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: corner voxels, unused code, generate past count
		send(vfcm_pkg::FUNC_GEN, 30'h0, 12'h0, 1'b0);
		send(vfcm_pkg::FUNC_UNUSED, 30'h3fffffff, 12'hfff, 1'b0);
		send(vfcm_pkg::FUNC_APPEND, 30'h0, 12'hfff, 1'b0);
		send(vfcm_pkg::FUNC_APPEND, vfcm_pkg::morton_enc(10'd0, 10'd1, 10'd0), 12'h0, 1'b0);
		send(vfcm_pkg::FUNC_APPEND, vfcm_pkg::morton_enc(10'd1, 10'd0, 10'd0), 12'h0, 1'b0);
		send(vfcm_pkg::FUNC_APPEND, vfcm_pkg::morton_enc(10'd0, 10'd0, 10'd1), 12'h0, 1'b0);
		send(vfcm_pkg::FUNC_APPEND, 30'h3fffffff, 12'h0, 1'b0);
		for (int i = 0; i < 5; i++) send(vfcm_pkg::FUNC_GEN, 30'h0, 12'(i), 1'b0);
		send(vfcm_pkg::FUNC_GEN, 30'h0, 12'd5, 1'b0);
		send(vfcm_pkg::FUNC_GEN, 30'h0, 12'hfff, 1'b0);
		send(vfcm_pkg::FUNC_CLEAR, 30'h3fffffff, 12'hfff, 1'b0);
		// unsorted table
		send(vfcm_pkg::FUNC_APPEND, vfcm_pkg::morton_enc(10'd5, 10'd5, 10'd5), 12'h0, 1'b0);
		send(vfcm_pkg::FUNC_APPEND, vfcm_pkg::morton_enc(10'd4, 10'd5, 10'd5), 12'h0, 1'b0);
		send(vfcm_pkg::FUNC_APPEND, vfcm_pkg::morton_enc(10'd5, 10'd5, 10'd6), 12'h0, 1'b0);
		for (int i = 0; i < 3; i++) send(vfcm_pkg::FUNC_GEN, 30'h0, 12'(i), 1'b0);
		// long receiver hold while further generates wait at the stalled input
		build_cluster(1020, 1020, 1020, 4, 1'b0);
		hold_long = 1'b1;
		for (int i = 0; i < 6; i++)
			send(vfcm_pkg::FUNC_GEN, 30'h0, 12'($urandom_range(0, cur_count - 1)), 1'b0);
		// random phase
		while (sent < 420) begin
			sz = $urandom_range(2, 4);
			lim = (1 << vfcm_pkg::LEVELS) - sz;
			case ($urandom_range(0, 5))
				0: build_cluster(lim, $urandom_range(0, lim), 0, sz, 1'b1);
				default: build_cluster($urandom_range(0, lim), $urandom_range(0, lim),
					$urandom_range(0, lim), sz, 1'b1);
			endcase
			for (int i = 0; i < 20; i++) begin
				case ($urandom_range(0, 9))
					0: send(vfcm_pkg::FUNC_UNUSED, 30'($urandom), 12'($urandom), 1'b1);
					1: begin
						rk = 30'($urandom);
						send(vfcm_pkg::FUNC_APPEND, rk, 12'($urandom), 1'b1);
					end
					2: send(vfcm_pkg::FUNC_GEN, 30'($urandom),
						12'(cur_count + $urandom_range(0, 3)), 1'b1);
					default: send(vfcm_pkg::FUNC_GEN, 30'($urandom),
						cur_count ? 12'($urandom_range(0, cur_count - 1)) : 12'h0, 1'b1);
				endcase
			end
		end
		send(vfcm_pkg::FUNC_GEN, 30'h0, 12'hfff, 1'b1);
		send(vfcm_pkg::FUNC_GEN, 30'h0, 12'd0, 1'b1);
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		wait (stim_done);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
